[src/pwvc_pkg.sv]
// Shared types and constants for the wear vote classifier.
`default_nettype none
package pwvc_pkg;

  localparam int SAMPLE_BITS = 20;
  localparam int PROD_BITS   = SAMPLE_BITS + 5;
  localparam int COUNT_BITS  = 4;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 4;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [PROD_BITS-1:0]   prod_t;
  typedef logic [COUNT_BITS-1:0]  count_t;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_ARM    = 2'd1,
    CMD_STOP   = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DETECT_ENABLE  = 2'd0,
    CFG_VOTES_REQUIRED = 2'd1,
    CFG_MAX_SAMPLES    = 2'd2
  } cfg_idx_t;

  localparam logic   DETECT_ENABLE_RESET  = 1'b1;
  localparam count_t VOTES_REQUIRED_RESET = count_t'(3);
  localparam count_t MAX_SAMPLES_RESET    = count_t'(4);

  typedef struct packed {
    logic valid;
    logic worn;
  } decision_t;

endpackage
`default_nettype wire

[src/pwvc_if.sv]
// Channel interfaces for sensor words and decision words.
`default_nettype none
interface pwvc_in_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           cmd;
  pwvc_pkg::sample_t    red;
  pwvc_pkg::sample_t    infrared;
  pwvc_pkg::sample_t    green;
  pwvc_pkg::sample_t    ambient;

  modport source (output valid, output cmd, output red, output infrared,
                  output green, output ambient, input ready);
  modport sink   (input valid, input cmd, input red, input infrared,
                  input green, input ambient, output ready);
endinterface

interface pwvc_out_if;
  logic valid;
  logic ready;
  logic worn;

  modport source (output valid, output worn, input ready);
  modport sink   (input valid, input worn, output ready);
endinterface
`default_nettype wire

[src/pwvc_spectrum_test.sv]
// Skin-like spectrum and low ambient test on one sample.
`default_nettype none
module pwvc_spectrum_test (
  input  wire pwvc_pkg::sample_t red,
  input  wire pwvc_pkg::sample_t infrared,
  input  wire pwvc_pkg::sample_t green,
  input  wire pwvc_pkg::sample_t ambient,
  output logic                   match
);

  pwvc_pkg::prod_t r;
  pwvc_pkg::prod_t ir;
  pwvc_pkg::prod_t g;
  pwvc_pkg::prod_t amb;
  logic            ambient_ok;
  logic            ratios_ok;

  assign r   = pwvc_pkg::prod_t'(red);
  assign ir  = pwvc_pkg::prod_t'(infrared);
  assign g   = pwvc_pkg::prod_t'(green);
  assign amb = pwvc_pkg::prod_t'(ambient);

  always_comb begin
    ambient_ok  = (amb * pwvc_pkg::prod_t'(25) <= g * pwvc_pkg::prod_t'(3)) &&
                  (amb * pwvc_pkg::prod_t'(4) <= r) &&
                  (amb * pwvc_pkg::prod_t'(10) <= ir * pwvc_pkg::prod_t'(3));
    ratios_ok   = (g * pwvc_pkg::prod_t'(10) >= r * pwvc_pkg::prod_t'(11)) &&
                  (r * pwvc_pkg::prod_t'(20) >= ir * pwvc_pkg::prod_t'(21)) &&
                  (ir * pwvc_pkg::prod_t'(2) >= amb * pwvc_pkg::prod_t'(3));
    match       = ambient_ok && ratios_ok;
  end

endmodule
`default_nettype wire

[src/pwvc_vote_ctrl.sv]
// Configuration registers, capture window state and vote counting.
`default_nettype none
module pwvc_vote_ctrl (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_we,
  input  wire [pwvc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire [pwvc_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  wire                               step,
  input  wire pwvc_pkg::cmd_t               cmd,
  input  wire                               match,
  output pwvc_pkg::decision_t               decision
);

  logic                 detect_enable;
  pwvc_pkg::count_t     votes_required;
  pwvc_pkg::count_t     max_samples;

  logic                 armed;
  pwvc_pkg::count_t     samples_seen;
  pwvc_pkg::count_t     positive_votes;
  logic                 armed_next;
  pwvc_pkg::count_t     samples_seen_next;
  pwvc_pkg::count_t     positive_votes_next;

  pwvc_pkg::count_t     seen_inc;
  pwvc_pkg::count_t     votes_inc;
  logic                 vote_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      detect_enable  <= pwvc_pkg::DETECT_ENABLE_RESET;
      votes_required <= pwvc_pkg::VOTES_REQUIRED_RESET;
      max_samples    <= pwvc_pkg::MAX_SAMPLES_RESET;
    end else if (cfg_we) begin
      case (pwvc_pkg::cfg_idx_t'(cfg_index))
        pwvc_pkg::CFG_DETECT_ENABLE:  detect_enable  <= cfg_data[0];
        pwvc_pkg::CFG_VOTES_REQUIRED: votes_required <= pwvc_pkg::count_t'(cfg_data);
        pwvc_pkg::CFG_MAX_SAMPLES:    max_samples    <= pwvc_pkg::count_t'(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    seen_inc            = samples_seen + pwvc_pkg::count_t'(1);
    votes_inc           = positive_votes + pwvc_pkg::count_t'(match);
    vote_ok             = votes_inc >= votes_required;
    armed_next          = armed;
    samples_seen_next   = samples_seen;
    positive_votes_next = positive_votes;
    decision            = '0;
    if (step) begin
      case (cmd)
        pwvc_pkg::CMD_ARM: begin
          if (detect_enable) begin
            armed_next          = 1'b1;
            samples_seen_next   = '0;
            positive_votes_next = '0;
          end
        end
        pwvc_pkg::CMD_STOP: begin
          armed_next          = 1'b0;
          samples_seen_next   = '0;
          positive_votes_next = '0;
        end
        pwvc_pkg::CMD_SAMPLE: begin
          if (armed) begin
            if (vote_ok || seen_inc >= max_samples) begin
              decision.valid      = 1'b1;
              decision.worn       = vote_ok;
              armed_next          = 1'b0;
              samples_seen_next   = '0;
              positive_votes_next = '0;
            end else begin
              samples_seen_next   = seen_inc;
              positive_votes_next = votes_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed          <= 1'b0;
      samples_seen   <= '0;
      positive_votes <= '0;
    end else begin
      armed          <= armed_next;
      samples_seen   <= samples_seen_next;
      positive_votes <= positive_votes_next;
    end
  end

endmodule
`default_nettype wire

[src/ppg_wear_vote_classifier.sv]
// Top level: input register, spectrum test, vote control and decision register.
//
//   channel    dir   handshake      payload
//   samples    in    valid/ready    cmd, red, infrared, green, ambient
//   decision   out   valid/ready    worn
//   cfg        in    cfg_we         cfg_index, cfg_data
//
// One word per cycle while no decision is held; a decision passes through the input
// register, then the decision register, before it is on the output.
// Sync active-high reset clears window state and valids and resets the config.
// A held decision stalls the input register; samples.ready stays high while the
// input register is empty or can drain into the decision register.
`default_nettype none
module ppg_wear_vote_classifier (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_we,
  input  wire [pwvc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire [pwvc_pkg::CFG_DATA_BITS-1:0] cfg_data,
  pwvc_in_if.sink                           samples,
  pwvc_out_if.source                        decision
);

  logic                s1_valid;
  pwvc_pkg::cmd_t      s1_cmd;
  pwvc_pkg::sample_t   s1_red;
  pwvc_pkg::sample_t   s1_infrared;
  pwvc_pkg::sample_t   s1_green;
  pwvc_pkg::sample_t   s1_ambient;

  logic                out_valid;
  logic                out_worn;

  logic                advance;
  logic                step;
  logic                match;
  pwvc_pkg::decision_t verdict;

  assign advance       = !out_valid || decision.ready;
  assign step          = s1_valid && advance;
  assign samples.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.ready && samples.valid) begin
      s1_cmd      <= pwvc_pkg::cmd_t'(samples.cmd);
      s1_red      <= samples.red;
      s1_infrared <= samples.infrared;
      s1_green    <= samples.green;
      s1_ambient  <= samples.ambient;
    end
  end

  pwvc_spectrum_test u_test (
    .red      (s1_red),
    .infrared (s1_infrared),
    .green    (s1_green),
    .ambient  (s1_ambient),
    .match    (match)
  );

  pwvc_vote_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .cmd       (s1_cmd),
    .match     (match),
    .decision  (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (verdict.valid) begin
      out_valid <= 1'b1;
    end else if (decision.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (verdict.valid) begin
      out_worn <= verdict.worn;
    end
  end

  assign decision.valid = out_valid;
  assign decision.worn  = out_worn;

endmodule
`default_nettype wire
